@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the decoder.
// Each macro expands to one labeled concurrent assertion with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/utf8d_pkg.sv @@
// Package for the UTF-8 to UTF-32 decoder: byte class constants and
// lead-byte decode functions. No dependencies.
package utf8d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 31;
  localparam int unsigned PendW   = 3;
  localparam int unsigned ContW   = 6;
  localparam int unsigned OutDataW = 32;

  localparam logic [ByteW-1:0] ContSel = 8'hC0;
  localparam logic [ByteW-1:0] ContTag = 8'h80;
  localparam logic [ByteW-1:0] ContBits = 8'h3F;

  // Sequence length started by byte b: 0 stray/illegal, 1 ASCII, 2..6 lead
  function automatic logic [PendW-1:0] seq_len(input logic [ByteW-1:0] b);
    logic [PendW-1:0] len;
    begin
      if (b < 8'h80) len = 3'd1;
      else if (b < 8'hC0) len = 3'd0;
      else if (b < 8'hE0) len = 3'd2;
      else if (b < 8'hF0) len = 3'd3;
      else if (b < 8'hF8) len = 3'd4;
      else if (b < 8'hFC) len = 3'd5;
      else if (b < 8'hFE) len = 3'd6;
      else len = 3'd0;
      return len;
    end
  endfunction

  // Payload bits of a lead byte for a sequence of len bytes
  function automatic logic [CpW-1:0] lead_payload(input logic [ByteW-1:0] b,
                                                  input logic [PendW-1:0] len);
    logic [ByteW-1:0] bits;
    begin
      case (len)
        3'd2: bits = b & 8'h1F;
        3'd3: bits = b & 8'h0F;
        3'd4: bits = b & 8'h07;
        3'd5: bits = b & 8'h03;
        3'd6: bits = b & 8'h01;
        default: bits = b & 8'h7F;
      endcase
      return {{(CpW-ByteW){1'b0}}, bits};
    end
  endfunction

  function automatic logic is_cont(input logic [ByteW-1:0] b);
    return (b & ContSel) == ContTag;
  endfunction

endpackage

@@ rtl/utf8_to_utf32_decoder.sv @@
// UTF-8 to UTF-32 stream decoder, top level.
// Depends on utf8d_pkg for byte classification and lead-byte decode.
//
// Usage:
//   Slave stream: one UTF-8 byte per item in s_axis_tdata; s_axis_tlast marks
//   end of stream and flushes an open sequence (the byte is then ignored).
//   Master stream: one code point per item in m_axis_tdata[30:0]; m_axis_tuser
//   is set when the code point is the partial value of a sequence cut short
//   by end of stream. Bytes that complete no code point give no item.
//   A completed result is registered in the output register, or in the skid
//   entry while the output stalls. Throughput: one byte per cycle while the
//   skid entry is empty; the byte decode and the six-bit shift of the
//   accumulator sit between the decoder state registers and the output register.
//   Stall: an output register plus one skid entry part the two sides; the
//   decoder keeps taking bytes while a result waits, and drops s_axis_tready
//   only when a second result is parked in the skid entry.
//   Reset: asynchronous, active low; clears the open sequence and empties
//   both output entries.
module utf8_to_utf32_decoder
  import utf8d_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,   // stream_end
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [30:0] code_point, [31] zero fill
  output logic                m_axis_tuser    // truncated
);

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           trunc;
  } result_t;

  logic [CpW-1:0]   acc_q, acc_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic             out_valid_q, skid_valid_q;
  result_t          out_q, skid_q;

  logic             accept;
  logic             res_valid;
  result_t          res;
  logic [PendW-1:0] len;
  logic [CpW-1:0]   acc_shift;
  logic             take_out;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign len       = seq_len(s_axis_tdata);
  assign acc_shift = {acc_q[CpW-ContW-1:0], s_axis_tdata[ContW-1:0]};

  // Decode one byte against the open sequence
  always_comb begin
    acc_d     = acc_q;
    pend_d    = pend_q;
    res_valid = 1'b0;
    res.cp    = acc_q;
    res.trunc = 1'b0;
    if (accept) begin
      if (s_axis_tlast) begin
        // flush: emit partial value if a sequence is open
        res_valid = (pend_q != '0);
        res.trunc = 1'b1;
        acc_d     = '0;
        pend_d    = '0;
      end else if ((pend_q != '0) && is_cont(s_axis_tdata)) begin
        // continuation: shift in six bits
        pend_d = pend_q - 3'd1;
        res.cp = acc_shift;
        if (pend_q == 3'd1) begin
          res_valid = 1'b1;
          acc_d     = '0;
        end else begin
          acc_d = acc_shift;
        end
      end else begin
        // fresh byte, possibly after a broken sequence
        acc_d  = '0;
        pend_d = '0;
        if (len == 3'd1) begin
          res_valid = 1'b1;
          res.cp    = {{(CpW-ByteW){1'b0}}, s_axis_tdata};
        end else if (len != 3'd0) begin
          acc_d  = lead_payload(s_axis_tdata, len);
          pend_d = len - 3'd1;
        end
      end
    end
  end

  // Hold decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

  // Output register with one skid entry
  assign take_out = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take_out) begin
      out_valid_q  <= skid_valid_q || res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_out) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.cp};
  assign m_axis_tuser  = out_q.trunc;

endmodule

@@ rtl/utf8d_checker.sv @@
// Port-level checker for the UTF-8 decoder, bound to the top level.
// Depends on utf8d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8d_checker
  import utf8d_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [ByteW-1:0]    s_axis_tdata,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  logic s_acc;
  logic out_free;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Stalled result item holds
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Code point never uses the fill bit
  `ASSERT_SAME(a_fill, clk_i, rst_ni, m_axis_tvalid, !m_axis_tdata[OutDataW-1])

  // ASCII byte appears next cycle unchanged when the output is free
  `ASSERT_NEXT(a_ascii, clk_i, rst_ni, s_acc && !s_axis_tlast && !s_axis_tdata[7] && out_free,
    m_axis_tvalid && !m_axis_tuser && (m_axis_tdata == {24'd0, $past(s_axis_tdata)}))

  // End of stream only yields a truncated item
  `ASSERT_NEXT(a_flush, clk_i, rst_ni, s_acc && s_axis_tlast && out_free,
    !m_axis_tvalid || m_axis_tuser)

endmodule

bind utf8_to_utf32_decoder utf8d_checker u_utf8d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ bench/utf8_to_utf32_decoder_test.sv @@
// Self-checking bench for utf8_to_utf32_decoder: directed table, then random
// UTF-8 traffic with bursty input and a stalling output, checked item by item.
// Depends on utf8d_pkg for widths and continuation byte constants.
module utf8_to_utf32_decoder_test
  import utf8d_pkg::*;
;

  localparam int NumDirected   = 26;
  localparam int RandomItems   = 1750;
  localparam int WatchdogLimit = 4000;
  localparam int LongHoldLen   = 300;
  localparam int LongHoldAfter = 150;

  // How the expected result of a stimulus row is obtained
  typedef enum logic [1:0] {
    CHECK_MODEL,  // from the decode predictor
    CHECK_NONE,   // no result, typed in
    CHECK_GIVEN   // result typed in
  } check_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    check_e           check;
    logic [CpW-1:0]   cp;
    logic             trunc;
  } feed_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           trunc;
  } cp_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata;   // [7:0] data_byte
  logic                s_axis_tlast;   // stream_end
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [30:0] code_point, [31] zero fill
  logic                m_axis_tuser;   // truncated

  // Directed rows: extremes, each lead length and each broken-stream case
  feed_t directed_rows [NumDirected] = '{
    '{8'h00, 1'b0, CHECK_GIVEN, 31'h0, 1'b0},           // lowest ASCII after reset
    '{8'h7F, 1'b0, CHECK_GIVEN, 31'h7F, 1'b0},          // highest ASCII
    '{8'h80, 1'b0, CHECK_NONE,  31'h0, 1'b0},           // stray continuation
    '{8'hBF, 1'b0, CHECK_NONE,  31'h0, 1'b0},
    '{8'hFE, 1'b0, CHECK_NONE,  31'h0, 1'b0},           // illegal bytes
    '{8'hFF, 1'b0, CHECK_NONE,  31'h0, 1'b0},
    '{8'hFF, 1'b1, CHECK_NONE,  31'h0, 1'b0},           // end while idle
    '{8'hC2, 1'b0, CHECK_MODEL, 31'h0, 1'b0},           // two-byte form
    '{8'hA9, 1'b0, CHECK_MODEL, 31'h0, 1'b0},
    '{8'hFD, 1'b0, CHECK_NONE,  31'h0, 1'b0},           // six-byte form, all ones
    '{8'hBF, 1'b0, CHECK_NONE,  31'h0, 1'b0},
    '{8'hBF, 1'b0, CHECK_NONE,  31'h0, 1'b0},
    '{8'hBF, 1'b0, CHECK_NONE,  31'h0, 1'b0},
    '{8'hBF, 1'b0, CHECK_NONE,  31'h0, 1'b0},
    '{8'hBF, 1'b0, CHECK_GIVEN, 31'h7FFF_FFFF, 1'b0},
    '{8'hF0, 1'b0, CHECK_MODEL, 31'h0, 1'b0},           // four-byte lead broken by ASCII
    '{8'h41, 1'b0, CHECK_MODEL, 31'h0, 1'b0},
    '{8'hE0, 1'b0, CHECK_MODEL, 31'h0, 1'b0},           // three-byte lead broken by a lead
    '{8'hC3, 1'b0, CHECK_MODEL, 31'h0, 1'b0},
    '{8'hA0, 1'b0, CHECK_MODEL, 31'h0, 1'b0},
    '{8'hE1, 1'b0, CHECK_MODEL, 31'h0, 1'b0},           // broken by an illegal byte
    '{8'hFF, 1'b0, CHECK_NONE,  31'h0, 1'b0},
    '{8'hF8, 1'b0, CHECK_MODEL, 31'h0, 1'b0},           // five-byte lead cut by end
    '{8'h88, 1'b0, CHECK_MODEL, 31'h0, 1'b0},
    '{8'h00, 1'b1, CHECK_MODEL, 31'h0, 1'b0},
    '{8'hAA, 1'b1, CHECK_NONE,  31'h0, 1'b0}            // repeated end
  };

  feed_t      byte_feed [$];
  feed_t      current_item;
  cp_result_t pending_cps [$];

  // Predictor state
  logic [CpW-1:0]   acc_bits;
  logic [PendW-1:0] seq_left;

  int errors      = 0;
  int n_items     = 0;
  int n_results   = 0;
  int n_truncated = 0;
  int quiet_cycles = 0;

  utf8_to_utf32_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Advance the decoder state by one item; return 1 when it yields a code point
  function automatic logic decode_byte(input logic [ByteW-1:0] b, input logic last,
                                       output logic [CpW-1:0] cp, output logic tr);
    logic [PendW-1:0] len;
    cp = '0;
    tr = 1'b0;
    if (last) begin
      if (seq_left != '0) begin
        cp = acc_bits;
        tr = 1'b1;
        acc_bits = '0;
        seq_left = '0;
        return 1'b1;
      end
      acc_bits = '0;
      return 1'b0;
    end
    if (seq_left != '0) begin
      if ((b & ContSel) == ContTag) begin
        acc_bits = {acc_bits[CpW-ContW-1:0], ContW'(b & ContBits)};
        seq_left = seq_left - 1'b1;
        if (seq_left == '0) begin
          cp = acc_bits;
          acc_bits = '0;
          return 1'b1;
        end
        return 1'b0;
      end
      // Broken sequence: drop the partial value, then take the byte afresh
      acc_bits = '0;
      seq_left = '0;
    end
    if (b < 8'h80) len = 3'd1;
    else if (b < 8'hC0) len = 3'd0;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else if (b < 8'hFE) len = 3'd6;
    else len = 3'd0;
    if (len == 3'd0) return 1'b0;
    if (len == 3'd1) begin
      cp = CpW'(b);
      return 1'b1;
    end
    acc_bits = CpW'(b & (8'h7F >> len));
    seq_left = len - 1'b1;
    return 1'b0;
  endfunction

  task automatic feed_byte(input logic [ByteW-1:0] b, input logic last);
    byte_feed.push_back('{b, last, CHECK_MODEL, 31'h0, 1'b0});
  endtask

  // Predict on each accepted input item, check each accepted result item
  always @(posedge clk_i) begin : monitor
    logic [CpW-1:0] cp;
    logic           tr;
    logic           hit;
    cp_result_t     want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        hit = decode_byte(s_axis_tdata, s_axis_tlast, cp, tr);
        n_items++;
        case (current_item.check)
          CHECK_MODEL: begin
            if (hit) pending_cps.push_back('{cp, tr});
          end
          CHECK_GIVEN: begin
            pending_cps.push_back('{current_item.cp, current_item.trunc});
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (m_axis_tuser) n_truncated++;
        if (pending_cps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: code point %h truncated %b",
                   $realtime, m_axis_tdata, m_axis_tuser);
        end else begin
          want = pending_cps.pop_front();
          if (m_axis_tdata != {1'b0, want.cp}) begin
            errors++;
            $display("%0t: code point mismatch: expected %h, actual %h",
                     $realtime, {1'b0, want.cp}, m_axis_tdata);
          end
          if (m_axis_tuser != want.trunc) begin
            errors++;
            $display("%0t: truncated flag mismatch: expected %b, actual %b",
                     $realtime, want.trunc, m_axis_tuser);
          end
        end
      end
    end
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("%0t: no item moved for %0d cycles", $realtime, quiet_cycles);
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // Receiver: stretches of steady, random, sparse and stalled ready, one long hold
  initial begin : receiver
    int  stretch;
    int  mode;
    bit  held;
    m_axis_tready = 1'b0;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      stretch = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      repeat (stretch) begin
        @(negedge clk_i);
        if (!held && n_results >= LongHoldAfter) begin
          // Hold off long enough for the block to fill and stall its input
          held = 1'b1;
          m_axis_tready = 1'b0;
          repeat (LongHoldLen) @(negedge clk_i);
        end
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = 1'($urandom_range(0, 1));
          2: m_axis_tready = ($urandom_range(0, 3) == 0);
          default: m_axis_tready = 1'b0;
        endcase
      end
    end
  end

  initial begin : main
    int               burst;
    int               gap;
    int               pick;
    int               len;
    int               conts;
    logic [ByteW-1:0] b;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    current_item = '0;
    acc_bits = '0;
    seq_left = '0;

    foreach (directed_rows[i]) byte_feed.push_back(directed_rows[i]);

    // Random part: mostly well-formed sequences, then broken, cut and noise
    while (byte_feed.size() < NumDirected + RandomItems) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(1, 6);
      if (pick < 88) begin
        case (len)
          1: b = {1'b0, 7'($urandom)};
          2: b = 8'hC0 | 8'($urandom_range(0, 31));
          3: b = 8'hE0 | 8'($urandom_range(0, 15));
          4: b = 8'hF0 | 8'($urandom_range(0, 7));
          5: b = 8'hF8 | 8'($urandom_range(0, 3));
          default: b = 8'hFC | 8'($urandom_range(0, 1));
        endcase
        feed_byte(b, 1'b0);
        if (len > 1) begin
          conts = (pick < 70) ? len - 1 : $urandom_range(0, len - 2);
          repeat (conts) feed_byte({2'b10, 6'($urandom)}, 1'b0);
          if (pick >= 70 && pick < 80) begin
            // Break the sequence with a byte that is not a continuation
            do b = 8'($urandom); while ((b & ContSel) == ContTag);
            feed_byte(b, 1'b0);
          end else if (pick >= 80) begin
            feed_byte(8'($urandom), 1'b1);
          end
        end
      end else begin
        feed_byte(8'($urandom), ($urandom_range(0, 4) == 0));
      end
    end

    // Hold reset, then release it at a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Sender: bursts of items with random gaps; two pauses until drained
    burst = 0;
    foreach (byte_feed[i]) begin
      if (i == NumDirected || i == NumDirected + RandomItems / 2) begin
        s_axis_tvalid = 1'b0;
        while (pending_cps.size() != 0) @(negedge clk_i);
      end
      if (burst == 0) begin
        s_axis_tvalid = 1'b0;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        repeat (gap) @(negedge clk_i);
        burst = $urandom_range(1, 30);
      end
      current_item = byte_feed[i];
      s_axis_tdata = byte_feed[i].data;
      s_axis_tlast = byte_feed[i].last;
      s_axis_tvalid = 1'b1;
      do @(posedge clk_i); while (!s_axis_tready);
      @(negedge clk_i);
      burst--;
    end
    s_axis_tvalid = 1'b0;

    // Drain, then keep watching for stray results
    while (pending_cps.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d bytes (%0d directed), checked %0d code points, %0d cut short by end",
             n_items, NumDirected, n_results, n_truncated);
    $display("Covered long output stall, drained pauses and %0d mismatches", errors);
    if (errors == 0 && pending_cps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
